/* design/lbbi_pkg.sv */
// Shared constants for the line and box boundary intersection unit.
`default_nettype none

package lbbi_pkg;

    // Default coordinate format: signed Q16.16
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Integer x bounds are unsigned and this wide
    localparam int XB_WIDTH = 16;

    // Boundaries, in the order they are reported
    localparam int NUM_EDGES = 4;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_X_LO = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_X_HI = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_Y_LO = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_Y_HI = 2'd3;

endpackage

`default_nettype wire

/* design/line_box_boundary_intersect_unit.sv */
// Top level: intersects a line with the four sides of a configured rectangle.
//
// Input items on s_t* carry a point and a direction of a line, each coordinate
// signed Q(COORD_WIDTH-FRAC_BITS).FRAC_BITS. The rectangle is set through the
// cfg_* write port (integer x bounds, Q y bounds); the user must write it only
// while the unit is idle, and the unit does not enforce this. For every input
// item one result item leaves on m_t*: up to two distinct intersections inside
// the closed rectangle in left, right, bottom, top order, zero where missing,
// the number of survivors and a flag when that is not two. Each side reduces to
// one signed division, done by a restoring divider that is unrolled into one
// register stage per quotient bit, four lanes wide. NW is the numerator width
// (67 bits for Q16.16); one item is accepted every cycle unless the output stalls.
// A stall on m_tready freezes the whole pipeline, and s_tready drops with it;
// nothing is lost or repeated. Reset (aresetn low, synchronous) clears all
// valid bits and the bound registers to zero.
`default_nettype none

module line_box_boundary_intersect_unit
    import lbbi_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // config write port
    input  wire logic                         cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0]        cfg_addr,
    input  wire logic [COORD_WIDTH-1:0]       cfg_wdata,
    // input items
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // point_x, point_y, dir_x, dir_y, zero pad
    input  wire logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    // result items
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // first_x, first_y, second_x, second_y, kept_count, count_bad, zero pad
    output logic [((4*COORD_WIDTH+4+7)/8)*8-1:0] m_tdata
);

    localparam int CW    = COORD_WIDTH;
    localparam int XQW   = XB_WIDTH + FRAC_BITS + 1;
    localparam int CRW   = (CW > XQW) ? CW : XQW;
    localparam int DW    = CRW + 1;
    localparam int PW    = DW + CW;
    localparam int NW    = DW + CW + 1;
    localparam int OUT_W = ((4*CW+4+7)/8)*8;
    localparam int OPAD  = OUT_W - (4*CW + 4);

    localparam logic signed [NW-1:0] SAT_HI = NW'((longint'(1) <<< (CW-1)) - 1);
    localparam logic signed [NW-1:0] SAT_LO = ~SAT_HI;

    // ---------------------------------------------------------------
    // Bound registers
    logic [XB_WIDTH-1:0]   x_lo_reg, x_hi_reg;
    logic signed [CW-1:0]  y_lo_reg, y_hi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_lo_reg <= '0;
            x_hi_reg <= '0;
            y_lo_reg <= '0;
            y_hi_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_X_LO: x_lo_reg <= cfg_wdata[XB_WIDTH-1:0];
                REG_X_HI: x_hi_reg <= cfg_wdata[XB_WIDTH-1:0];
                REG_Y_LO: y_lo_reg <= cfg_wdata;
                REG_Y_HI: y_hi_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // bounds as Q values, wide enough for both axes
    logic signed [XQW-1:0] xq_lo, xq_hi;
    logic signed [CRW-1:0] xlo_c, xhi_c, ylo_c, yhi_c;
    assign xq_lo = {1'b0, x_lo_reg, {FRAC_BITS{1'b0}}};
    assign xq_hi = {1'b0, x_hi_reg, {FRAC_BITS{1'b0}}};
    assign xlo_c = CRW'(xq_lo);
    assign xhi_c = CRW'(xq_hi);
    assign ylo_c = CRW'(y_lo_reg);
    assign yhi_c = CRW'(y_hi_reg);

    // global advance: move when the output slot is free or being taken
    logic en;
    logic m_valid_reg;
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // ---------------------------------------------------------------
    // Stage 1: offsets from the point to each bound
    logic                 s1_valid_reg;
    logic signed [CW-1:0] s1_px_reg, s1_py_reg, s1_ux_reg, s1_uy_reg;
    logic signed [DW-1:0] s1_d_reg [0:NUM_EDGES-1];

    logic signed [CW-1:0] in_px, in_py, in_ux, in_uy;
    assign in_px = s_tdata[CW-1:0];
    assign in_py = s_tdata[2*CW-1:CW];
    assign in_ux = s_tdata[3*CW-1:2*CW];
    assign in_uy = s_tdata[4*CW-1:3*CW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_px_reg   <= in_px;
            s1_py_reg   <= in_py;
            s1_ux_reg   <= in_ux;
            s1_uy_reg   <= in_uy;
            s1_d_reg[0] <= DW'(xlo_c) - DW'(in_px);
            s1_d_reg[1] <= DW'(xhi_c) - DW'(in_px);
            s1_d_reg[2] <= DW'(ylo_c) - DW'(in_py);
            s1_d_reg[3] <= DW'(yhi_c) - DW'(in_py);
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: products
    logic                   s2_valid_reg;
    logic signed [PW-1:0]   s2_p_reg [0:NUM_EDGES-1];
    logic signed [2*CW-1:0] s2_pyux_reg, s2_pxuy_reg;
    logic signed [CW-1:0]   s2_ux_reg, s2_uy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_p_reg[0] <= PW'(s1_d_reg[0]) * PW'(s1_uy_reg);
            s2_p_reg[1] <= PW'(s1_d_reg[1]) * PW'(s1_uy_reg);
            s2_p_reg[2] <= PW'(s1_d_reg[2]) * PW'(s1_ux_reg);
            s2_p_reg[3] <= PW'(s1_d_reg[3]) * PW'(s1_ux_reg);
            s2_pyux_reg <= (2*CW)'(s1_py_reg) * (2*CW)'(s1_ux_reg);
            s2_pxuy_reg <= (2*CW)'(s1_px_reg) * (2*CW)'(s1_uy_reg);
            s2_ux_reg   <= s1_ux_reg;
            s2_uy_reg   <= s1_uy_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: numerators to sign and magnitude, load the divider
    // dv_n holds the numerator bits shifting out and the quotient shifting in
    logic              dv_valid_reg [0:NW];
    logic [NW-1:0]     dv_n_reg     [0:NW][0:NUM_EDGES-1];
    logic [CW-1:0]     dv_r_reg     [0:NW][0:NUM_EDGES-1];
    logic              dv_neg_reg   [0:NW][0:NUM_EDGES-1];
    logic [CW-1:0]     dv_den_reg   [0:NW][0:1];
    logic              dv_nz_reg    [0:NW][0:1];

    logic signed [NW-1:0] num [0:NUM_EDGES-1];
    always_comb begin
        num[0] = NW'(s2_p_reg[0]) + NW'(s2_pyux_reg);
        num[1] = NW'(s2_p_reg[1]) + NW'(s2_pyux_reg);
        num[2] = NW'(s2_p_reg[2]) + NW'(s2_pxuy_reg);
        num[3] = NW'(s2_p_reg[3]) + NW'(s2_pxuy_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg[0] <= 1'b0;
        end else if (en) begin
            dv_valid_reg[0] <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < NUM_EDGES; l++) begin
                dv_n_reg[0][l]   <= num[l][NW-1] ? NW'(-num[l]) : NW'(num[l]);
                dv_r_reg[0][l]   <= '0;
                dv_neg_reg[0][l] <= num[l][NW-1] ^
                                    ((l < 2) ? s2_ux_reg[CW-1] : s2_uy_reg[CW-1]);
            end
            dv_den_reg[0][0] <= s2_ux_reg[CW-1] ? CW'(-s2_ux_reg) : CW'(s2_ux_reg);
            dv_den_reg[0][1] <= s2_uy_reg[CW-1] ? CW'(-s2_uy_reg) : CW'(s2_uy_reg);
            dv_nz_reg[0][0]  <= (s2_ux_reg != '0);
            dv_nz_reg[0][1]  <= (s2_uy_reg != '0);
        end
    end

    // ---------------------------------------------------------------
    // Divider: one quotient bit per stage, four lanes
    for (genvar g = 0; g < NW; g++) begin : g_div
        logic [NW-1:0] n_next [0:NUM_EDGES-1];
        logic [CW-1:0] r_next [0:NUM_EDGES-1];

        always_comb begin
            logic [CW:0] trial;
            logic [CW:0] dext;
            for (int l = 0; l < NUM_EDGES; l++) begin
                trial = {dv_r_reg[g][l], dv_n_reg[g][l][NW-1]};
                dext  = {1'b0, dv_den_reg[g][l>>1]};
                if (trial >= dext) begin
                    r_next[l] = CW'(trial - dext);
                    n_next[l] = {dv_n_reg[g][l][NW-2:0], 1'b1};
                end else begin
                    r_next[l] = trial[CW-1:0];
                    n_next[l] = {dv_n_reg[g][l][NW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[g+1] <= 1'b0;
            end else if (en) begin
                dv_valid_reg[g+1] <= dv_valid_reg[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int l = 0; l < NUM_EDGES; l++) begin
                    dv_n_reg[g+1][l]   <= n_next[l];
                    dv_r_reg[g+1][l]   <= r_next[l];
                    dv_neg_reg[g+1][l] <= dv_neg_reg[g][l];
                end
                for (int a = 0; a < 2; a++) begin
                    dv_den_reg[g+1][a] <= dv_den_reg[g][a];
                    dv_nz_reg[g+1][a]  <= dv_nz_reg[g][a];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Range stage: build each point, test it against the closed rectangle
    logic                 rg_valid_reg;
    logic signed [NW-1:0] rg_ix_reg [0:NUM_EDGES-1];
    logic signed [NW-1:0] rg_iy_reg [0:NUM_EDGES-1];
    logic [NUM_EDGES-1:0] rg_keep_reg;

    logic signed [NW-1:0] xlo_n, xhi_n, ylo_n, yhi_n;
    assign xlo_n = NW'(xlo_c);
    assign xhi_n = NW'(xhi_c);
    assign ylo_n = NW'(ylo_c);
    assign yhi_n = NW'(yhi_c);

    logic signed [NW-1:0] ix [0:NUM_EDGES-1];
    logic signed [NW-1:0] iy [0:NUM_EDGES-1];
    logic [NUM_EDGES-1:0] keep;

    always_comb begin
        logic signed [NW-1:0] q;
        logic                 ok;
        for (int l = 0; l < NUM_EDGES; l++) begin
            q = dv_neg_reg[NW][l] ? NW'(-dv_n_reg[NW][l]) : NW'(dv_n_reg[NW][l]);
            case (l)
                0: begin
                    ix[l] = xlo_n;
                    iy[l] = q;
                end
                1: begin
                    ix[l] = xhi_n;
                    iy[l] = q;
                end
                2: begin
                    ix[l] = q;
                    iy[l] = ylo_n;
                end
                default: begin
                    ix[l] = q;
                    iy[l] = yhi_n;
                end
            endcase
            // a side parallel to the line, or of zero length, gives nothing
            if (l < 2) ok = dv_nz_reg[NW][0] && (y_lo_reg != y_hi_reg);
            else       ok = dv_nz_reg[NW][1] && (x_lo_reg != x_hi_reg);
            keep[l] = ok && (ix[l] >= xlo_n) && (ix[l] <= xhi_n) &&
                      (iy[l] >= ylo_n) && (iy[l] <= yhi_n);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rg_valid_reg <= 1'b0;
        end else if (en) begin
            rg_valid_reg <= dv_valid_reg[NW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < NUM_EDGES; l++) begin
                rg_ix_reg[l] <= ix[l];
                rg_iy_reg[l] <= iy[l];
            end
            rg_keep_reg <= keep;
        end
    end

    // ---------------------------------------------------------------
    // Output stage: drop repeats, pick the first two, saturate
    function automatic logic [CW-1:0] sat_coord(input logic signed [NW-1:0] v);
        logic signed [NW-1:0] t;
        t = v;
        if (t > SAT_HI) t = SAT_HI;
        if (t < SAT_LO) t = SAT_LO;
        return t[CW-1:0];
    endfunction

    logic [NUM_EDGES-1:0] uniq;
    logic [CW-1:0]        fx, fy, sx, sy;
    logic [2:0]           cnt;

    always_comb begin
        uniq = rg_keep_reg;
        for (int j = 1; j < NUM_EDGES; j++) begin
            for (int i = 0; i < j; i++) begin
                if (rg_keep_reg[i] && rg_ix_reg[i] == rg_ix_reg[j] &&
                    rg_iy_reg[i] == rg_iy_reg[j]) begin
                    uniq[j] = 1'b0;
                end
            end
        end
        fx  = '0;
        fy  = '0;
        sx  = '0;
        sy  = '0;
        cnt = '0;
        for (int j = 0; j < NUM_EDGES; j++) begin
            if (uniq[j]) begin
                if (cnt == 3'd0) begin
                    fx = sat_coord(rg_ix_reg[j]);
                    fy = sat_coord(rg_iy_reg[j]);
                end else if (cnt == 3'd1) begin
                    sx = sat_coord(rg_ix_reg[j]);
                    sy = sat_coord(rg_iy_reg[j]);
                end
                cnt = cnt + 3'd1;
            end
        end
    end

    logic [OUT_W-1:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= rg_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= {{OPAD{1'b0}}, (cnt != 3'd2), cnt, sy, sx, fy, fx};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire
